// File: rtl/core/cascaded_altitude_pi_controller_defines.svh
// ----------------------------------------------------------------------------
// Cascaded altitude PI controller assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CASCADED_ALTITUDE_PI_CONTROLLER_DEFINES_SVH
`define CASCADED_ALTITUDE_PI_CONTROLLER_DEFINES_SVH

// same-cycle implication
`define CAPC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CAPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/capc_pkg.sv
// ----------------------------------------------------------------------------
// Cascaded altitude PI controller package
// Sequencer states, register indexes, reset values and shared types.
// ----------------------------------------------------------------------------
package capc_pkg;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_MPOS,
        S_MINT,
        S_MVEL,
        S_SUM,
        S_FIN
    } state_t;

    localparam int CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_POS_GAIN    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INT_GAIN    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_VEL_GAIN    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPEED_LIMIT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_INTEG_LIMIT = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_OUT_LIMIT   = 3'd5;

    localparam logic [15:0] POS_GAIN_RST    = 16'd256;
    localparam logic [15:0] INT_GAIN_RST    = 16'd16;
    localparam logic [15:0] VEL_GAIN_RST    = 16'd256;
    localparam logic [14:0] SPEED_LIMIT_RST = 15'd1600;
    localparam logic [14:0] INTEG_LIMIT_RST = 15'd4256;
    localparam logic [10:0] OUT_LIMIT_RST   = 11'd400;

    typedef struct packed
    {
        logic               en;
        logic [15:0]        gain;
        logic signed [16:0] opnd;
    } mul_req_t;

endpackage

// File: rtl/core/capc_mul.sv
// ----------------------------------------------------------------------------
// Cascaded altitude PI controller shared multiplier
// Unsigned Q8.8 gain times signed 17-bit operand, registered product.
// ----------------------------------------------------------------------------
module capc_mul
    import capc_pkg::*;
(
    input  logic               clk,
    input  mul_req_t           req,
    output logic signed [32:0] prod
);

    logic signed [16:0] gain_s;
    logic signed [33:0] full;
    logic signed [32:0] prod_reg;

    assign gain_s = $signed({1'b0, req.gain});
    assign full   = gain_s * req.opnd;

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            prod_reg <= full[32:0];
        end
    end

    assign prod = prod_reg;

endmodule

// File: rtl/core/cascaded_altitude_pi_controller.sv
// ----------------------------------------------------------------------------
// Cascaded altitude PI controller
// Position P loop feeding a velocity P loop with a clamped integrator.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries setpoint, meas_velocity and
//   meas_position, all signed Q11.4. Output channel (out_valid/out_ready)
//   carries drive, a signed integer clamped to +-out_limit. One sample gives
//   exactly one drive value.
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   the six gain and limit registers; cfg_ready is always high, unknown
//   indexes are dropped. Write only while no sample is in flight.
//   Each sample runs through the states MPOS, MINT, MVEL, SUM and FIN: a
//   single 17x17 multiplier is reused for the position, integral and
//   velocity products, followed by a sum and a clamp step.
//   in_ready is high only while the sequencer is idle.
//   A finished drive waits in an output register; the next sample is taken
//   meanwhile and its final step holds until that register is free.
//   Reset loads the default gains and limits and clears the integrator.
// ----------------------------------------------------------------------------
`include "cascaded_altitude_pi_controller_defines.svh"

module cascaded_altitude_pi_controller
    import capc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic signed [15:0]     setpoint,
    input  logic signed [15:0]     meas_velocity,
    input  logic signed [15:0]     meas_position,

    output logic                   out_valid,
    input  logic                   out_ready,
    output logic signed [11:0]     drive,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0]            cfg_data
);

    state_t state_reg;
    state_t state_next;

    logic [15:0] pos_gain_reg;
    logic [15:0] int_gain_reg;
    logic [15:0] vel_gain_reg;
    logic [14:0] speed_limit_reg;
    logic [14:0] integ_limit_reg;
    logic [10:0] out_limit_reg;

    logic signed [15:0] integ_reg;
    logic signed [15:0] integ_next;
    logic               out_valid_reg;
    logic signed [11:0] drive_reg;
    logic signed [11:0] drive_next;

    logic signed [16:0] err_reg;
    logic signed [15:0] vel_reg;
    logic signed [15:0] vd_reg;
    logic signed [15:0] vd_next;
    logic signed [33:0] sum_reg;
    logic signed [33:0] sum_next;

    mul_req_t           mul_req;
    logic signed [32:0] prod;
    logic signed [24:0] prod_shr;
    logic signed [24:0] spd_lim;
    logic signed [25:0] integ_sum;
    logic signed [25:0] ilim;
    logic signed [16:0] vel_diff;
    logic signed [21:0] quot;
    logic signed [21:0] olim;

    logic in_xfer;
    logic out_free;
    logic load_vd;
    logic load_integ;
    logic load_sum;
    logic load_drive;

    logic signed [15:0] vd_bound;
    logic signed [15:0] integ_bound;
    logic signed [11:0] drive_bound;

    assign in_xfer   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;

    capc_mul u_mul
    (
        .clk  (clk),
        .req  (mul_req),
        .prod (prod)
    );

    // datapath
    assign prod_shr  = prod[32:8];
    assign spd_lim   = $signed({10'b0, speed_limit_reg});
    assign ilim      = $signed({11'b0, integ_limit_reg});
    assign olim      = $signed({11'b0, out_limit_reg});
    assign integ_sum = $signed({{10{integ_reg[15]}}, integ_reg})
                     + $signed({prod_shr[24], prod_shr});
    assign vel_diff  = $signed({vd_reg[15], vd_reg}) - $signed({vel_reg[15], vel_reg});
    assign sum_next  = $signed({prod[32], prod})
                     + $signed({{10{integ_reg[15]}}, integ_reg, 8'b0});
    assign quot      = sum_reg[33:12]
                     + $signed({21'b0, sum_reg[33] && (sum_reg[11:0] != 12'd0)});

    always_comb
    begin
        if (prod_shr > spd_lim)
        begin
            vd_next = spd_lim[15:0];
        end
        else if (prod_shr < -spd_lim)
        begin
            vd_next = -spd_lim[15:0];
        end
        else
        begin
            vd_next = prod_shr[15:0];
        end
    end

    always_comb
    begin
        if (integ_sum > ilim)
        begin
            integ_next = ilim[15:0];
        end
        else if (integ_sum < -ilim)
        begin
            integ_next = -ilim[15:0];
        end
        else
        begin
            integ_next = integ_sum[15:0];
        end
    end

    always_comb
    begin
        if (quot > olim)
        begin
            drive_next = olim[11:0];
        end
        else if (quot < -olim)
        begin
            drive_next = -olim[11:0];
        end
        else
        begin
            drive_next = quot[11:0];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_MPOS;
                end
            end
            S_MPOS: state_next = S_MINT;
            S_MINT: state_next = S_MVEL;
            S_MVEL: state_next = S_SUM;
            S_SUM:  state_next = S_FIN;
            S_FIN:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready     = 1'b0;
        load_vd      = 1'b0;
        load_integ   = 1'b0;
        load_sum     = 1'b0;
        load_drive   = 1'b0;
        mul_req.en   = 1'b0;
        mul_req.gain = pos_gain_reg;
        mul_req.opnd = err_reg;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
            end
            S_MPOS:
            begin
                mul_req.en = 1'b1;
            end
            S_MINT:
            begin
                load_vd      = 1'b1;
                mul_req.en   = 1'b1;
                mul_req.gain = int_gain_reg;
            end
            S_MVEL:
            begin
                load_integ   = 1'b1;
                mul_req.en   = 1'b1;
                mul_req.gain = vel_gain_reg;
                mul_req.opnd = vel_diff;
            end
            S_SUM:
            begin
                load_sum = 1'b1;
            end
            S_FIN:
            begin
                load_drive = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            pos_gain_reg    <= POS_GAIN_RST;
            int_gain_reg    <= INT_GAIN_RST;
            vel_gain_reg    <= VEL_GAIN_RST;
            speed_limit_reg <= SPEED_LIMIT_RST;
            integ_limit_reg <= INTEG_LIMIT_RST;
            out_limit_reg   <= OUT_LIMIT_RST;
            integ_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_POS_GAIN:    pos_gain_reg    <= cfg_data;
                    REG_INT_GAIN:    int_gain_reg    <= cfg_data;
                    REG_VEL_GAIN:    vel_gain_reg    <= cfg_data;
                    REG_SPEED_LIMIT: speed_limit_reg <= cfg_data[14:0];
                    REG_INTEG_LIMIT: integ_limit_reg <= cfg_data[14:0];
                    REG_OUT_LIMIT:   out_limit_reg   <= cfg_data[10:0];
                    default:         ;
                endcase
            end
            if (load_integ)
            begin
                integ_reg <= integ_next;
            end
            if (load_drive)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            err_reg <= $signed({setpoint[15], setpoint})
                     - $signed({meas_position[15], meas_position});
            vel_reg <= meas_velocity;
        end
        if (load_vd)
        begin
            vd_reg <= vd_next;
        end
        if (load_sum)
        begin
            sum_reg <= sum_next;
        end
        if (load_drive)
        begin
            drive_reg <= drive_next;
        end
    end

    assign vd_bound    = $signed({1'b0, speed_limit_reg});
    assign integ_bound = $signed({1'b0, integ_limit_reg});
    assign drive_bound = $signed({1'b0, out_limit_reg});

    `CAPC_ASSERT_NEXT(a_vd_clamped, state_reg == S_MINT,
        (vd_reg <= vd_bound) && (vd_reg >= -vd_bound), "desired velocity out of bound")
    `CAPC_ASSERT_NEXT(a_integ_clamped, state_reg == S_MVEL,
        (integ_reg <= integ_bound) && (integ_reg >= -integ_bound), "integrator out of bound")
    `CAPC_ASSERT_NOW(a_drive_clamped, out_valid_reg,
        (drive_reg <= drive_bound) && (drive_reg >= -drive_bound), "drive out of bound")
    `CAPC_ASSERT_NEXT(a_fin_delivers, (state_reg == S_FIN) && out_free,
        out_valid_reg && (state_reg == S_IDLE), "final step did not post result")

endmodule
